[hw/rtl/bca_pkg.sv]
// ----------------------------------------------------------------------------
// bca_pkg: shared types and constants of the chunk allocator
// Field widths, command, status and register codes, sequencer states and the
// result bundle of the shared divider.
// ----------------------------------------------------------------------------
package bca_pkg;

   localparam int DATA_W      = 32;  // addresses and divider dividend
   localparam int CS_W        = 17;  // chunk_size register
   localparam int TS_W        = 25;  // total_size register
   localparam int IDX_OUT_W   = 8;   // chunk_index field
   localparam int CSR_IDX_W   = 2;
   localparam int ROW_BITS    = 8;   // free-map bits per memory row
   localparam int ROW_SHIFT   = 3;
   localparam int DIV_STEPS   = 32;  // one quotient bit per cycle
   localparam int DIV_CNT_W   = 6;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_NOMEM  = 2'd1,
      STATUS_BADPTR = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE  = 2'd0,
      CSR_CHUNK = 2'd1,
      CSR_TOTAL = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COUNT,
      ST_SCAN,
      ST_ALLOC_MUL,
      ST_ALLOC_ADD,
      ST_FREE_DIV,
      ST_FREE_WR,
      ST_DONE
   } fsm_state_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DATA_W-1:0] quotient;
      logic [CS_W-1:0]   remainder;
   } div_out_type;

endpackage

[hw/rtl/bca_req_if.sv]
// ----------------------------------------------------------------------------
// bca_req_if: request channel
// Valid/ready channel carrying one allocate or free request.
// ----------------------------------------------------------------------------
interface bca_req_if import bca_pkg::*;;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [DATA_W-1:0] address;

   modport source (output valid, output cmd, output address, input ready);
   modport sink   (input valid, input cmd, input address, output ready);
endinterface

[hw/rtl/bca_rsp_if.sv]
// ----------------------------------------------------------------------------
// bca_rsp_if: response channel
// Valid/ready channel carrying one allocator result.
// ----------------------------------------------------------------------------
interface bca_rsp_if import bca_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   logic [DATA_W-1:0]    chunk_address;
   logic [IDX_OUT_W-1:0] chunk_index;

   modport source (output valid, output status, output chunk_address,
                   output chunk_index, input ready);
   modport sink   (input valid, input status, input chunk_address,
                   input chunk_index, output ready);
endinterface

[hw/rtl/bca_csr_if.sv]
// ----------------------------------------------------------------------------
// bca_csr_if: register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface bca_csr_if import bca_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [DATA_W-1:0]    wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

[hw/rtl/bitmap_chunk_allocator.sv]
// Allocate: ST_SCAN checks the free-map rows (8 chunks each) in order, then
//   ST_ALLOC_MUL and ST_ALLOC_ADD form the address; ST_DONE answers, also when none is free.
// Free: ST_FREE_DIV waits on the 32-step shared divider, then ST_FREE_WR; a rejected
//   free, and a free of address zero, go straight to ST_DONE. One request at a time,
//   plus a wait for a busy response register; a waiting response does not block the
//   next request. Reset: registers take their defaults, a clearing pass marks every
//   chunk free, then a chunk-count division.
// ----------------------------------------------------------------------------
// bitmap_chunk_allocator: first-fit fixed-size chunk allocator
// Keeps a one-bit-per-chunk free map in a row memory. Allocation scans rows
// in order for the lowest free chunk; free turns an address into an index
// through a shared iterative divider.
// ----------------------------------------------------------------------------
module bitmap_chunk_allocator import bca_pkg::*; #(
   parameter int MAX_CHUNKS = 256
) (
   input  logic     clock,
   input  logic     reset,
   bca_req_if.sink  req_bus,
   bca_rsp_if.source rsp_bus,
   bca_csr_if.sink  csr_bus
);

   // free map geometry
   localparam int ROWS  = (MAX_CHUNKS + ROW_BITS - 1) / ROW_BITS;
   localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IW    = $clog2(MAX_CHUNKS);
   localparam int CW    = $clog2(MAX_CHUNKS + 1);
   localparam int CMP_W = CW + 4;
   localparam int MUL_W = IW + CS_W;

   // sequencer and working registers
   fsm_state_type state_ff, state_in;
   logic [RAW-1:0]       row_ff, row_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [DATA_W-1:0]    prod_ff, prod_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 stale_ff, stale_in;

   // configuration registers
   logic [DATA_W-1:0]    base_ff, base_in;
   logic [CS_W-1:0]      chunk_ff, chunk_in;
   logic [TS_W-1:0]      total_ff, total_in;

   // finished result, then the response register
   status_type           res_status_ff, res_status_in;
   logic [DATA_W-1:0]    res_addr_ff, res_addr_in;
   logic [IDX_OUT_W-1:0] res_idx_ff, res_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [IDX_OUT_W-1:0] rsp_idx_ff, rsp_idx_in;

   // free-map memory, one row of chunk bits per entry, 1 = free
   logic [ROW_BITS-1:0]  map_mem [ROWS];
   logic [ROW_BITS-1:0]  rd_data_ff;
   logic                 mem_we;
   logic [RAW-1:0]       mem_waddr;
   logic [RAW-1:0]       mem_raddr;
   logic [ROW_BITS-1:0]  mem_wdata;

   // shared divider
   logic                 div_start;
   logic [DATA_W-1:0]    div_dividend;
   div_out_type          div_res;

   // scan helpers
   logic [CMP_W-1:0]     row_base;
   logic [ROW_BITS-1:0]  avail;
   logic [2:0]           pick;
   logic                 rows_left;
   logic [MUL_W-1:0]     mul_full;
   logic [IW-1:0]        q_idx;
   logic [2:0]           free_bit;
   logic                 free_bad;
   logic                 req_ready;

   bca_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (chunk_ff),
      .result   (div_res)
   );

   // Mask the fetched row to chunks below the count and find the lowest free.
   always_comb begin
      row_base = CMP_W'({row_ff, 3'b000});
      for (int j = 0; j < ROW_BITS; j++) begin
         avail[j] = rd_data_ff[j] && ((row_base + CMP_W'(j)) < CMP_W'(count_ff));
      end
      pick = '0;
      for (int j = ROW_BITS - 1; j >= 0; j--) begin
         if (avail[j]) begin
            pick = 3'(j);
         end
      end
      rows_left = (row_base + CMP_W'(ROW_BITS)) < CMP_W'(count_ff);
   end

   assign mul_full = MUL_W'(idx_ff) * MUL_W'(chunk_ff);
   assign q_idx    = div_res.quotient[IW-1:0];
   assign free_bit = 3'(idx_ff);

   // Reject a free whose offset is off the chunk grid, past the region or
   // past the clamped chunk count.
   assign free_bad = (div_res.remainder != '0)
                  || (div_res.quotient >= DATA_W'(total_ff))
                  || (div_res.quotient >= DATA_W'(count_ff));

   // Sequencer: next state, datapath controls and register updates.
   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      idx_in        = idx_ff;
      prod_in       = prod_ff;
      count_in      = count_ff;
      stale_in      = stale_ff;
      base_in       = base_ff;
      chunk_in      = chunk_ff;
      total_in      = total_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_idx_in    = res_idx_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;

      mem_we       = 1'b0;
      mem_waddr    = row_ff;
      mem_wdata    = rd_data_ff;
      mem_raddr    = row_ff;
      div_start    = 1'b0;
      div_dividend = req_bus.address - base_ff;
      req_ready    = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            // sweep the map once, marking every chunk free
            mem_we    = 1'b1;
            mem_wdata = '1;
            if (row_ff == RAW'(ROWS - 1)) begin
               row_in   = '0;
               state_in = ST_IDLE;
            end else begin
               row_in = row_ff + RAW'(1);
            end
         end

         ST_IDLE: begin
            mem_raddr = '0;
            if (stale_ff) begin
               // chunk_size or total_size moved: refresh the chunk count
               div_start    = 1'b1;
               div_dividend = DATA_W'(total_ff);
               stale_in     = 1'b0;
               state_in     = ST_COUNT;
            end else begin
               req_ready = 1'b1;
               if (req_bus.valid) begin
                  if (req_bus.cmd == CMD_ALLOC) begin
                     row_in   = '0;
                     state_in = ST_SCAN;
                  end else if (req_bus.address == '0) begin
                     res_status_in = STATUS_OK;
                     res_addr_in   = '0;
                     res_idx_in    = '0;
                     state_in      = ST_DONE;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_FREE_DIV;
                  end
               end
            end
         end

         ST_COUNT: begin
            if (div_res.done) begin
               if (chunk_ff == '0) begin
                  count_in = '0;
               end else if (div_res.quotient >= DATA_W'(MAX_CHUNKS)) begin
                  count_in = CW'(MAX_CHUNKS);
               end else begin
                  count_in = CW'(div_res.quotient);
               end
               state_in = ST_IDLE;
            end
         end

         ST_SCAN: begin
            // fetch the next row while checking this one
            mem_raddr = row_ff + RAW'(1);
            if (avail != '0) begin
               mem_we    = 1'b1;
               mem_wdata = rd_data_ff & ~(ROW_BITS'(1) << pick);
               idx_in    = IW'({row_ff, pick});
               state_in  = ST_ALLOC_MUL;
            end else if (!rows_left) begin
               res_status_in = STATUS_NOMEM;
               res_addr_in   = '0;
               res_idx_in    = '0;
               state_in      = ST_DONE;
            end else begin
               row_in = row_ff + RAW'(1);
            end
         end

         ST_ALLOC_MUL: begin
            prod_in  = DATA_W'(mul_full);
            state_in = ST_ALLOC_ADD;
         end

         ST_ALLOC_ADD: begin
            res_status_in = STATUS_OK;
            res_addr_in   = base_ff + prod_ff;
            res_idx_in    = IDX_OUT_W'(idx_ff);
            state_in      = ST_DONE;
         end

         ST_FREE_DIV: begin
            mem_raddr = RAW'(q_idx >> ROW_SHIFT);
            if (div_res.done) begin
               if (free_bad) begin
                  res_status_in = STATUS_BADPTR;
                  res_addr_in   = '0;
                  res_idx_in    = '0;
                  state_in      = ST_DONE;
               end else begin
                  idx_in   = q_idx;
                  state_in = ST_FREE_WR;
               end
            end
         end

         ST_FREE_WR: begin
            // read-modify-write of the row: set the chunk's free bit
            mem_we        = 1'b1;
            mem_waddr     = RAW'(idx_ff >> ROW_SHIFT);
            mem_wdata     = rd_data_ff | (ROW_BITS'(1) << free_bit);
            res_status_in = STATUS_OK;
            res_addr_in   = '0;
            res_idx_in    = IDX_OUT_W'(idx_ff);
            state_in      = ST_DONE;
         end

         ST_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_idx_in    = res_idx_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes; a size change marks the chunk count for refresh
      if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            CSR_BASE: begin
               base_in = csr_bus.wr_data;
            end
            CSR_CHUNK: begin
               chunk_in = csr_bus.wr_data[CS_W-1:0];
               stale_in = 1'b1;
            end
            CSR_TOTAL: begin
               total_in = csr_bus.wr_data[TS_W-1:0];
               stale_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         count_ff     <= '0;
         stale_ff     <= 1'b1;
         base_ff      <= '0;
         chunk_ff     <= CS_W'(64);
         total_ff     <= TS_W'(16384);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         count_ff     <= count_in;
         stale_ff     <= stale_in;
         base_ff      <= base_in;
         chunk_ff     <= chunk_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      prod_ff       <= prod_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_idx_ff    <= res_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_idx_ff    <= rsp_idx_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= map_mem[mem_raddr];
   end

   assign req_bus.ready         = req_ready;
   assign csr_bus.ready         = 1'b1;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.chunk_address = rsp_addr_ff;
   assign rsp_bus.chunk_index   = rsp_idx_ff;

   // the divider is never restarted mid-division
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_res.busy)
      else $error("divider started while busy");

   // an allocation takes exactly one free chunk and frees none
   a_alloc_one_bit: assert property (@(posedge clock) disable iff (reset)
      (mem_we && state_ff == ST_SCAN)
         |-> ($countones(rd_data_ff & ~mem_wdata) == 1)
             && ((mem_wdata & ~rd_data_ff) == '0))
      else $error("allocation changed other than one free bit");

   // a response appears only out of the completion state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside completion");

endmodule

[hw/rtl/bca_div.sv]
// ----------------------------------------------------------------------------
// bca_div: radix-2 restoring divider
// Divides a 32-bit dividend by a 17-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module bca_div import bca_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [CS_W-1:0]   divisor,
   output div_out_type       result
);

   logic [CS_W-1:0]      rem_ff, rem_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [CS_W-1:0]      dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [CS_W:0] trial;
   logic [CS_W:0] diff;
   logic          fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DATA_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      fits  = (trial >= {1'b0, dsr_ff});

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // keep the partial remainder, shift in the next quotient bit
         rem_in = fits ? diff[CS_W-1:0] : trial[CS_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign result.busy      = busy_ff;
   assign result.done      = done_ff;
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;

endmodule
